// ----- hdl/ffba_pkg.sv -----
package ffba_pkg;

	localparam int POOL_WORDS = 4096;
	localparam int ADDR_W     = 12;
	localparam int SIZE_W     = 12;
	localparam int CNT_W      = 13;
	localparam int HDR_W      = 14;
	localparam int FREE_BIT   = 12;
	localparam int END_BIT    = 13;
	localparam int MIN_POOL   = 4;

	typedef enum logic [1:0] {
		FUNC_INIT    = 2'd0,
		FUNC_ALLOC   = 2'd1,
		FUNC_FREE    = 2'd2,
		FUNC_LARGEST = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ISSUE,
		S_INIT_HDR,
		S_INIT_END,
		S_WALK_A,
		S_SPLIT,
		S_WALK_L,
		S_FREE_WR,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		RD_ZERO,
		RD_NEXT,
		RD_FREE
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_INIT_HDR,
		WR_INIT_END,
		WR_GRANT,
		WR_REMAIN,
		WR_FREE
	} wr_sel_t;

	typedef struct packed {
		logic    accept;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		logic    step_alloc;
		logic    step_largest;
		logic    set_grant;
		logic    set_fail;
		logic    load_out;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  hdr_end;
		logic  hdr_free;
		logic  fits;
		logic  has_left;
		logic  past_end;
		logic  out_free;
	} stat_t;

endpackage

// ----- hdl/ffba_if.sv -----
interface ffba_in_if;
	import ffba_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        func;
	logic [CNT_W-1:0]  request_words;
	logic [ADDR_W-1:0] block_addr;

	modport source (output valid, output func, output request_words, output block_addr,
		input ready);
	modport sink (input valid, input func, input request_words, input block_addr,
		output ready);
endinterface

interface ffba_out_if;
	import ffba_pkg::*;

	logic              valid;
	logic              ready;
	logic              ok;
	logic [ADDR_W-1:0] granted_addr;
	logic [SIZE_W-1:0] largest_free;

	modport source (output valid, output ok, output granted_addr, output largest_free,
		input ready);
	modport sink (input valid, input ok, input granted_addr, input largest_free,
		output ready);
endinterface

// ----- hdl/ffba_ram.sv -----
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hdl/ffba_dp.sv -----
module ffba_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ffba_pkg::CNT_W-1:0]  cfg_wdata,
	input  logic [1:0]                  func,
	input  logic [ffba_pkg::CNT_W-1:0]  request_words,
	input  logic [ffba_pkg::ADDR_W-1:0] block_addr,
	input  ffba_pkg::cmd_t              cmd,
	output ffba_pkg::stat_t             st,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic                        ok,
	output logic [ffba_pkg::ADDR_W-1:0] granted_addr,
	output logic [ffba_pkg::SIZE_W-1:0] largest_free
);
	import ffba_pkg::*;

	logic [CNT_W-1:0]  pool_q;
	logic [CNT_W-1:0]  lim;
	logic [CNT_W-1:0]  lim_m1;
	logic [CNT_W-1:0]  lim_m2;

	func_t             func_q;
	logic [CNT_W-1:0]  req_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  start_q;
	logic [CNT_W-1:0]  room_q;
	logic [SIZE_W-1:0] best_q;
	logic              ok_q;
	logic [ADDR_W-1:0] granted_q;

	logic              out_valid_q;
	logic              out_ok_q;
	logic [ADDR_W-1:0] out_granted_q;
	logic [SIZE_W-1:0] out_largest_q;

	logic [HDR_W-1:0]  hdr;
	logic [SIZE_W-1:0] sz;
	logic [CNT_W-1:0]  inext;
	logic [CNT_W-1:0]  roomsum;
	logic [CNT_W-1:0]  left;
	logic [CNT_W-1:0]  room_m1;
	logic [ADDR_W-1:0] free_hdr;
	logic              free_bad;
	logic [ADDR_W-1:0] rem_addr;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [HDR_W-1:0]  wdata;
	logic [ADDR_W-1:0] raddr;

	// Effective pool size, saturated to the supported range.
	always_comb begin
		if (pool_q < CNT_W'(MIN_POOL)) begin
			lim = CNT_W'(MIN_POOL);
		end else if (pool_q > CNT_W'(POOL_WORDS)) begin
			lim = CNT_W'(POOL_WORDS);
		end else begin
			lim = pool_q;
		end
	end

	assign lim_m1   = lim - CNT_W'(1);
	assign lim_m2   = lim - CNT_W'(2);
	assign sz       = hdr[SIZE_W-1:0];
	assign inext    = i_q + CNT_W'(sz) + CNT_W'(1);
	assign roomsum  = room_q + CNT_W'(sz);
	assign left     = roomsum - req_q;
	assign room_m1  = room_q - CNT_W'(1);
	assign free_hdr = addr_q - ADDR_W'(1);
	assign free_bad = (addr_q == '0) || ({1'b0, free_hdr} >= lim);
	assign rem_addr = start_q[ADDR_W-1:0] + ADDR_W'(1) + req_q[ADDR_W-1:0];

	always_comb begin
		case (cmd.rd_sel)
			RD_ZERO: raddr = '0;
			RD_NEXT: raddr = inext[ADDR_W-1:0];
			RD_FREE: raddr = free_hdr;
			default: raddr = '0;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		case (cmd.wr_sel)
			WR_INIT_HDR: begin
				we    = 1'b1;
				waddr = '0;
				wdata = {1'b0, 1'b1, lim_m2[SIZE_W-1:0]};
			end
			WR_INIT_END: begin
				we    = 1'b1;
				waddr = lim_m1[ADDR_W-1:0];
				wdata = {1'b1, 1'b0, {SIZE_W{1'b0}}};
			end
			WR_GRANT: begin
				we    = 1'b1;
				waddr = start_q[ADDR_W-1:0];
				wdata = {2'b00, req_q[SIZE_W-1:0]};
			end
			WR_REMAIN: begin
				we    = 1'b1;
				waddr = rem_addr;
				wdata = {1'b0, 1'b1, room_m1[SIZE_W-1:0]};
			end
			WR_FREE: begin
				we    = !hdr[END_BIT] && !free_bad;
				waddr = free_hdr;
				wdata = hdr | (HDR_W'(1) << FREE_BIT);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	ffba_ram #(
		.WIDTH(HDR_W),
		.DEPTH(POOL_WORDS)
	) u_hdr_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(hdr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q      <= CNT_W'(POOL_WORDS);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pool_q <= cfg_wdata;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q    <= func_t'(func);
			req_q     <= request_words;
			addr_q    <= block_addr;
			i_q       <= '0;
			start_q   <= '0;
			room_q    <= '0;
			best_q    <= '0;
			ok_q      <= 1'b1;
			granted_q <= '0;
		end
		if (cmd.step_alloc) begin
			i_q <= inext;
			if (!hdr[FREE_BIT]) begin
				room_q  <= '0;
				start_q <= inext;
			end else begin
				room_q <= roomsum + CNT_W'(1);
			end
		end
		if (cmd.step_largest) begin
			i_q <= inext;
			if (hdr[FREE_BIT] && (sz > best_q)) begin
				best_q <= sz;
			end
		end
		if (cmd.set_grant) begin
			granted_q <= start_q[ADDR_W-1:0] + ADDR_W'(1);
			room_q    <= left;
		end
		if (cmd.set_fail) begin
			ok_q      <= 1'b0;
			granted_q <= '0;
		end
		if (cmd.load_out) begin
			out_ok_q      <= ok_q;
			out_granted_q <= granted_q;
			out_largest_q <= best_q;
		end
	end

	assign st.func     = func_q;
	assign st.hdr_end  = hdr[END_BIT];
	assign st.hdr_free = hdr[FREE_BIT];
	assign st.fits     = (req_q <= roomsum);
	assign st.has_left = (left != '0);
	assign st.past_end = (inext >= lim);
	assign st.out_free = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign ok           = out_ok_q;
	assign granted_addr = out_granted_q;
	assign largest_free = out_largest_q;
endmodule

// ----- hdl/ffba_ctrl.sv -----
module ffba_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ffba_pkg::stat_t st,
	output ffba_pkg::cmd_t  cmd
);
	import ffba_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = S_ISSUE;
				end
			end
			S_ISSUE: begin
				cmd.rd_sel = (st.func == FUNC_FREE) ? RD_FREE : RD_ZERO;
				case (st.func)
					FUNC_INIT:    state_nxt = S_INIT_HDR;
					FUNC_ALLOC:   state_nxt = S_WALK_A;
					FUNC_FREE:    state_nxt = S_FREE_WR;
					FUNC_LARGEST: state_nxt = S_WALK_L;
					default:      state_nxt = S_DONE;
				endcase
			end
			S_INIT_HDR: begin
				cmd.wr_sel = WR_INIT_HDR;
				state_nxt  = S_INIT_END;
			end
			S_INIT_END: begin
				cmd.wr_sel = WR_INIT_END;
				state_nxt  = S_DONE;
			end
			S_WALK_A: begin
				if (st.hdr_end) begin
					cmd.set_fail = 1'b1;
					state_nxt    = S_DONE;
				end else if (st.hdr_free && st.fits) begin
					cmd.wr_sel    = WR_GRANT;
					cmd.set_grant = 1'b1;
					state_nxt     = st.has_left ? S_SPLIT : S_DONE;
				end else begin
					cmd.step_alloc = 1'b1;
					cmd.rd_sel     = RD_NEXT;
					if (st.past_end) begin
						cmd.set_fail = 1'b1;
						state_nxt    = S_DONE;
					end
				end
			end
			S_SPLIT: begin
				cmd.wr_sel = WR_REMAIN;
				state_nxt  = S_DONE;
			end
			S_WALK_L: begin
				if (st.hdr_end) begin
					state_nxt = S_DONE;
				end else begin
					cmd.step_largest = 1'b1;
					cmd.rd_sel       = RD_NEXT;
					if (st.past_end) begin
						state_nxt = S_DONE;
					end
				end
			end
			S_FREE_WR: begin
				cmd.wr_sel = WR_FREE;
				state_nxt  = S_DONE;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_done_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && st.out_free) |=> (state_q == S_IDLE))
		else $error("result not handed off although output slot was free");

	a_split_after_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SPLIT) |-> ($past(state_q) == S_WALK_A && $past(cmd.set_grant)))
		else $error("remainder write without a preceding grant");

	a_free_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FREE_WR) |-> ($past(state_q) == S_ISSUE))
		else $error("free update without a header read");

	a_grant_fail_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.set_grant && cmd.set_fail))
		else $error("allocation both granted and failed");
`endif
endmodule

// ----- hdl/first_fit_block_allocator.sv -----
// First-fit block allocator. The pool is a run of up to 4096 header words kept in one
// block RAM; each block is led by a header holding its payload size and a free mark, and the
// last pool word holds an end marker. Each input beat carries one operation and produces
// exactly one output beat. Init lays out one free block plus the end marker. Free reads the
// block header and sets its free mark, except at address zero, outside the pool or on the
// end marker. Allocate and the largest-free query walk the headers from word 0 at one header
// per cycle. The number of headers visited is at most one per pool word, so it reaches the
// pool size when the pool is cut into zero-size blocks. An allocation that splits off a free
// remainder writes its header in another state. The walk rate is set by the RAM read port:
// the address of the next header is the current header's address plus its size plus one,
// computed from the registered read data and fed straight back to the read address. One
// operation is in flight at a time; the result sits in an output register, so the next beat
// is accepted while a result waits. Configuration (pool_words) is to be written by the user
// only while the block is idle; the block does not enforce this. Values below 4 or above
// 4096 are treated as 4 or 4096. Operating on the pool before init is not defined.
module first_fit_block_allocator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ffba_pkg::CNT_W-1:0] cfg_wdata,
	ffba_in_if.sink                    in_ch,
	ffba_out_if.source                 out_ch
);
	import ffba_pkg::*;

	cmd_t  cmd;
	stat_t st;

	// Sequencer: decides what the datapath does each cycle from its status flags.
	ffba_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.st      (st),
		.cmd     (cmd)
	);

	// Datapath: header RAM, walk pointer and accumulators, result and output registers.
	ffba_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.func         (in_ch.func),
		.request_words(in_ch.request_words),
		.block_addr   (in_ch.block_addr),
		.cmd          (cmd),
		.st           (st),
		.out_ready    (out_ch.ready),
		.out_valid    (out_ch.valid),
		.ok           (out_ch.ok),
		.granted_addr (out_ch.granted_addr),
		.largest_free (out_ch.largest_free)
	);
endmodule

// ----- tb/first_fit_block_allocator_tb.sv -----
`timescale 1ns / 1ps

module first_fit_block_allocator_tb;
	import ffba_pkg::*;

	// Watchdog budget. The slowest correct run walks at most one header per pool word in each
	// operation, plus random gaps and one long output hold-off. This limit
	// sits several times above that.
	localparam int CYCLE_LIMIT = 8000000;
	// Cycles to keep watching after the last result. This covers the longest
	// walk the pool allows, so a stray late beat is still caught.
	localparam int TAIL_CYCLES = 4200;
	// Length of the output hold-off that fills the block and backs up its input.
	localparam int HOLD_CYCLES = 500;

	// One operation beat as the testbench sees it.
	typedef struct packed {
		func_t             func;
		logic [CNT_W-1:0]  request_words;
		logic [ADDR_W-1:0] block_addr;
	} op_beat_t;

	// One result beat.
	typedef struct packed {
		logic              ok;
		logic [ADDR_W-1:0] granted_addr;
		logic [SIZE_W-1:0] largest_free;
	} alloc_result_t;

	// A directed row. When 'typed' is set, the expected result is the one
	// written in the row. Otherwise the pool mirror supplies it.
	typedef struct packed {
		logic [CNT_W-1:0]  pool;
		func_t             func;
		logic [CNT_W-1:0]  req;
		logic [ADDR_W-1:0] addr;
		bit                typed;
		logic              ok;
		logic [ADDR_W-1:0] granted;
		logic [SIZE_W-1:0] largest;
	} directed_row_t;

	// A random phase: pool setting, length, idling mix and special handling.
	typedef struct packed {
		logic [CNT_W-1:0] pool;
		int               items;
		int               idle_pct;
		int               stall_pct;
		bit               pressure;
		bit               with_init;
	} phase_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	ffba_in_if  op_ch ();
	ffba_out_if res_ch ();

	first_fit_block_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (op_ch),
		.out_ch    (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The testbench keeps its own copy of the pool. It holds the header words
	// and a flag per word that marks whether the word was ever written. Frees
	// that would read a never-written header are steered away from, because
	// the block leaves such words undefined.
	logic [HDR_W-1:0] header_mirror [POOL_WORDS];
	bit               hdr_written [POOL_WORDS];
	logic [CNT_W-1:0] pool_setting;
	int               live_blocks [$];
	alloc_result_t    pending_results [$];

	int  mismatch_count = 0;
	int  idle_pct = 0;
	int  stall_pct = 0;
	bit  holding = 1'b0;
	event hold_start;
	int unsigned cycle_count = 0;

	// The directed part. It starts from reset with the default pool. It goes
	// through failed allocations at the top of the request range and a
	// zero-size request. It fills the pool exactly, frees blocks twice and at
	// address zero, and merges a zero-size free block into its neighbor. It
	// then shrinks the pool without an init, so that the walk runs off the
	// pool, and works a minimum-size pool. There it frees the end marker and an
	// address beyond the pool. Last, it grows the pool back without an init.
	directed_row_t directed_rows [27] = '{
		'{13'd4096, FUNC_INIT,    13'd0,    12'd0,    1'b1, 1'b1, 12'd0, 12'd0},
		'{13'd4096, FUNC_LARGEST, 13'd0,    12'd0,    1'b1, 1'b1, 12'd0, 12'd4094},
		'{13'd4096, FUNC_ALLOC,   13'd8191, 12'd4095, 1'b1, 1'b0, 12'd0, 12'd0},
		'{13'd4096, FUNC_ALLOC,   13'd4095, 12'd0,    1'b1, 1'b0, 12'd0, 12'd0},
		'{13'd4096, FUNC_ALLOC,   13'd0,    12'd0,    1'b1, 1'b1, 12'd1, 12'd0},
		'{13'd4096, FUNC_ALLOC,   13'd4093, 12'd0,    1'b1, 1'b1, 12'd2, 12'd0},
		'{13'd4096, FUNC_LARGEST, 13'd0,    12'd0,    1'b1, 1'b1, 12'd0, 12'd0},
		'{13'd4096, FUNC_FREE,    13'd0,    12'd0,    1'b1, 1'b1, 12'd0, 12'd0},
		'{13'd4096, FUNC_FREE,    13'd0,    12'd2,    1'b1, 1'b1, 12'd0, 12'd0},
		'{13'd4096, FUNC_FREE,    13'd0,    12'd2,    1'b1, 1'b1, 12'd0, 12'd0},
		'{13'd4096, FUNC_FREE,    13'd0,    12'd1,    1'b1, 1'b1, 12'd0, 12'd0},
		'{13'd4096, FUNC_LARGEST, 13'd0,    12'd0,    1'b1, 1'b1, 12'd0, 12'd4093},
		'{13'd4096, FUNC_ALLOC,   13'd4094, 12'd0,    1'b1, 1'b1, 12'd1, 12'd0},
		'{13'd4096, FUNC_FREE,    13'd0,    12'd1,    1'b1, 1'b1, 12'd0, 12'd0},
		'{13'd4096, FUNC_ALLOC,   13'd100,  12'd0,    1'b0, 1'b0, 12'd0, 12'd0},
		'{13'd4096, FUNC_ALLOC,   13'd200,  12'd0,    1'b0, 1'b0, 12'd0, 12'd0},
		'{13'd4096, FUNC_FREE,    13'd0,    12'd1,    1'b0, 1'b0, 12'd0, 12'd0},
		'{13'd4096, FUNC_ALLOC,   13'd50,   12'd0,    1'b0, 1'b0, 12'd0, 12'd0},
		'{13'd50,   FUNC_ALLOC,   13'd10,   12'd0,    1'b0, 1'b0, 12'd0, 12'd0},
		'{13'd50,   FUNC_LARGEST, 13'd0,    12'd0,    1'b0, 1'b0, 12'd0, 12'd0},
		'{13'd0,    FUNC_INIT,    13'd0,    12'd0,    1'b1, 1'b1, 12'd0, 12'd0},
		'{13'd0,    FUNC_LARGEST, 13'd0,    12'd0,    1'b1, 1'b1, 12'd0, 12'd2},
		'{13'd0,    FUNC_ALLOC,   13'd2,    12'd0,    1'b1, 1'b1, 12'd1, 12'd0},
		'{13'd0,    FUNC_FREE,    13'd0,    12'd4,    1'b1, 1'b1, 12'd0, 12'd0},
		'{13'd0,    FUNC_FREE,    13'd0,    12'd4095, 1'b1, 1'b1, 12'd0, 12'd0},
		'{13'd8191, FUNC_LARGEST, 13'd0,    12'd0,    1'b0, 1'b0, 12'd0, 12'd0},
		'{13'd8191, FUNC_ALLOC,   13'd0,    12'd0,    1'b0, 1'b0, 12'd0, 12'd0}
	};

	// The random phases. Each phase has its own pool size and idling mix. One
	// phase holds the output back at its start. The last phase changes the
	// pool size but starts from the old layout.
	phase_t phases [5] = '{
		'{13'd4096, 60, 0,  0,  1'b0, 1'b1},
		'{13'd4,    40, 59, 0,  1'b0, 1'b1},
		'{13'd700,  60, 0,  59, 1'b0, 1'b1},
		'{13'd4096, 70, 16, 16, 1'b1, 1'b1},
		'{13'd1500, 60, 0,  0,  1'b0, 1'b0}
	};

	// Pool bound the block works with. Out-of-range settings saturate.
	function automatic int pool_limit();
		int p;
		p = int'(pool_setting);
		if (p < MIN_POOL) p = MIN_POOL;
		if (p > POOL_WORDS) p = POOL_WORDS;
		return p;
	endfunction

	function automatic logic [HDR_W-1:0] make_header(bit is_free, bit is_end, int size);
		logic [HDR_W-1:0] hdr;
		hdr = '0;
		hdr[SIZE_W-1:0] = size[SIZE_W-1:0];
		hdr[FREE_BIT] = is_free;
		hdr[END_BIT] = is_end;
		return hdr;
	endfunction

	// A read past the physical pool counts as the end marker.
	function automatic logic [HDR_W-1:0] mirror_read(int idx);
		if (idx >= POOL_WORDS) return make_header(1'b0, 1'b1, 0);
		return header_mirror[idx];
	endfunction

	function automatic void mirror_write(int idx, logic [HDR_W-1:0] hdr);
		if (idx < POOL_WORDS) begin
			header_mirror[idx] = hdr;
			hdr_written[idx] = 1'b1;
		end
	endfunction

	// First-fit walk. A run of free blocks is merged on the fly, and each
	// header in the run adds its own word to the room. When the run is big
	// enough, its head is marked used, and any word left over becomes a new
	// free header. Returns the payload address, or zero when nothing fits.
	function automatic int mirror_alloc(int req);
		int lim, idx, start, room, sz, left;
		logic [HDR_W-1:0] hdr;
		lim = pool_limit();
		idx = 0;
		start = 0;
		room = 0;
		while (idx < lim) begin
			hdr = mirror_read(idx);
			sz = int'(hdr[SIZE_W-1:0]);
			if (hdr[END_BIT]) return 0;
			if (!hdr[FREE_BIT]) begin
				room = 0;
				idx = idx + sz + 1;
				start = idx;
			end else begin
				room = room + sz;
				if (req > room) begin
					room = room + 1;
					idx = idx + sz + 1;
				end else begin
					left = room - req;
					mirror_write(start, make_header(1'b0, 1'b0, req));
					if (left >= 1) mirror_write(start + 1 + req, make_header(1'b1, 1'b0, left - 1));
					return start + 1;
				end
			end
		end
		return 0;
	endfunction

	function automatic int mirror_largest();
		int lim, idx, best, sz;
		logic [HDR_W-1:0] hdr;
		lim = pool_limit();
		idx = 0;
		best = 0;
		while (idx < lim) begin
			hdr = mirror_read(idx);
			sz = int'(hdr[SIZE_W-1:0]);
			if (hdr[END_BIT]) break;
			if (hdr[FREE_BIT] && sz > best) best = sz;
			idx = idx + sz + 1;
		end
		return (best > 4095) ? 4095 : best;
	endfunction

	// Computes the result of one operation and updates the pool mirror.
	function automatic alloc_result_t predict_operation(op_beat_t beat);
		alloc_result_t res;
		int lim, grant, addr, best;
		logic [HDR_W-1:0] hdr;
		res = '{ok: 1'b1, granted_addr: '0, largest_free: '0};
		lim = pool_limit();
		case (beat.func)
			FUNC_INIT: begin
				mirror_write(0, make_header(1'b1, 1'b0, lim - 2));
				mirror_write(lim - 1, make_header(1'b0, 1'b1, 0));
				live_blocks.delete();
			end
			FUNC_ALLOC: begin
				grant = mirror_alloc(int'(beat.request_words));
				res.ok = (grant != 0);
				res.granted_addr = grant[ADDR_W-1:0];
				if (grant != 0) live_blocks.push_back(grant);
			end
			FUNC_FREE: begin
				// Address zero, a header outside the pool and the end marker are
				// left untouched. The operation still reports success.
				addr = int'(beat.block_addr);
				if (addr != 0 && addr - 1 < lim) begin
					hdr = mirror_read(addr - 1);
					if (!hdr[END_BIT]) begin
						hdr[FREE_BIT] = 1'b1;
						mirror_write(addr - 1, hdr);
					end
				end
			end
			default: begin
				best = mirror_largest();
				res.largest_free = best[SIZE_W-1:0];
			end
		endcase
		return res;
	endfunction

	// Picks a random operation. Most frees target blocks that are live. Some
	// hit the end marker or a random word. A free never reads a header that
	// was never written: such an address falls back to zero. Most requests
	// are small, so the walks stay short, but a few span the whole 13-bit range.
	function automatic op_beat_t choose_operation(bit force_init);
		op_beat_t beat;
		int lim, pick, r, addr;
		lim = pool_limit();
		beat.func = FUNC_LARGEST;
		beat.request_words = CNT_W'($urandom_range(0, 8191));
		beat.block_addr = ADDR_W'($urandom_range(0, 4095));
		r = $urandom_range(0, 99);
		if (force_init || r < 4) begin
			beat.func = FUNC_INIT;
		end else if (r < 50) begin
			beat.func = FUNC_ALLOC;
			r = $urandom_range(0, 99);
			if (r < 70) beat.request_words = CNT_W'($urandom_range(0, lim / 32 + 1));
			else if (r < 90) beat.request_words = CNT_W'($urandom_range(0, lim / 4));
			else if (r < 96) beat.request_words = CNT_W'($urandom_range(0, lim));
		end else if (r < 80) begin
			beat.func = FUNC_FREE;
			r = $urandom_range(0, 99);
			if (r < 75 && live_blocks.size() != 0) begin
				pick = $urandom_range(0, live_blocks.size() - 1);
				beat.block_addr = ADDR_W'(live_blocks[pick]);
				live_blocks.delete(pick);
			end else if (r < 85) begin
				beat.block_addr = ADDR_W'(lim);
			end
			addr = int'(beat.block_addr);
			if (addr != 0 && addr - 1 < lim && !hdr_written[addr - 1]) beat.block_addr = '0;
		end
		return beat;
	endfunction

	// Queues the expected result, then offers the beat until it is accepted.
	// Random idle cycles come before the beat, as idle_pct asks. After the
	// accepting edge, valid stays high, so the caller can present the next beat
	// at once.
	task automatic offer_beat(input op_beat_t beat, input alloc_result_t expected);
		while ($urandom_range(0, 99) < idle_pct) begin
			op_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pending_results.push_back(expected);
		op_ch.valid         <= 1'b1;
		op_ch.func          <= beat.func;
		op_ch.request_words <= beat.request_words;
		op_ch.block_addr    <= beat.block_addr;
		@(posedge clk);
		while (!op_ch.ready) @(posedge clk);
	endtask

	// The pool size changes only while the block is idle. First the input goes
	// quiet. Then every outstanding result must come back, and a further wait
	// passes before the write.
	task automatic write_pool_words(input logic [CNT_W-1:0] value);
		op_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		pool_setting = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Result side. Each accepted beat is checked field by field against the
	// oldest queued result. Then ready is chosen for the next cycle. It stays
	// low through a hold-off, and otherwise follows the stall mix.
	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat arrived with no operation outstanding");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (res_ch.ok !== want.ok) begin
					$error("ok: expected %0d, actual %0d", want.ok, res_ch.ok);
					mismatch_count++;
				end
				if (res_ch.granted_addr !== want.granted_addr) begin
					$error("granted_addr: expected %0d, actual %0d",
						want.granted_addr, res_ch.granted_addr);
					mismatch_count++;
				end
				if (res_ch.largest_free !== want.largest_free) begin
					$error("largest_free: expected %0d, actual %0d",
						want.largest_free, res_ch.largest_free);
					mismatch_count++;
				end
			end
		end
		res_ch.ready <= !holding && ($urandom_range(0, 99) >= stall_pct);
	end

	// A long output hold-off, counted here. While it lasts, the sender keeps
	// offering beats. The block finishes one operation, parks the result, takes
	// one more beat and then stalls its input.
	always begin
		@(hold_start);
		holding = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		holding = 1'b0;
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		directed_row_t row;
		phase_t        ph;
		op_beat_t      beat;
		alloc_result_t expected;
		int            n;

		op_ch.valid         = 1'b0;
		op_ch.func          = FUNC_INIT;
		op_ch.request_words = '0;
		op_ch.block_addr    = '0;
		res_ch.ready        = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		arst_n              = 1'b0;

		// After reset, the mirror is blank and the pool setting is the full pool.
		foreach (hdr_written[i]) hdr_written[i] = 1'b0;
		pool_setting = CNT_W'(POOL_WORDS);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The directed table. Every row goes through the mirror, so the state
		// stays in step. Rows with a written result use that result instead.
		foreach (directed_rows[r]) begin
			row = directed_rows[r];
			if (row.pool != pool_setting) write_pool_words(row.pool);
			beat = '{func: row.func, request_words: row.req, block_addr: row.addr};
			expected = predict_operation(beat);
			if (row.typed) expected = '{ok: row.ok, granted_addr: row.granted,
				largest_free: row.largest};
			offer_beat(beat, expected);
		end

		// The random phases. Most beats form well-formed alloc/free traffic over
		// an initialized pool. A few are noise: oversized requests, stray frees
		// and a re-init in the middle of a phase.
		foreach (phases[p]) begin
			ph = phases[p];
			write_pool_words(ph.pool);
			idle_pct = ph.idle_pct;
			stall_pct = ph.stall_pct;
			if (ph.pressure) -> hold_start;
			for (n = 0; n < ph.items; n++) begin
				beat = choose_operation(ph.with_init && n == 0);
				expected = predict_operation(beat);
				offer_beat(beat, expected);
			end
		end

		op_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			mismatch_count++;
		end
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
